// ===== src/motion_command_line_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// Motion command line decoder assertion macros
// Short forms for the concurrent checks on the decoder ports.
// ----------------------------------------------------------------------------
`ifndef MOTION_COMMAND_LINE_DECODER_TOP_MACROS_SVH
`define MOTION_COMMAND_LINE_DECODER_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MCLD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MCLD_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/mcld_pkg.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder package
// Shared widths, codes, characters and the structs passed between modules.
// ----------------------------------------------------------------------------
package mcld_pkg;

    localparam int MAGNITUDE_BITS_DEFAULT = 24;

    localparam int CH_W       = 8;
    localparam int CFG_MAG_W  = 24;
    localparam int RATE_W     = 16;
    localparam int STEP_W     = 25;
    localparam int CMD_W      = 3;
    localparam int ERR_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_USED_W = ERR_W + 1 + 1 + STEP_W + RATE_W + 1;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_TDATA_W - OUT_USED_W;

    // Commands
    localparam logic [CMD_W-1:0] OPC_MOVE    = 3'd0;
    localparam logic [CMD_W-1:0] OPC_STATUS  = 3'd1;
    localparam logic [CMD_W-1:0] OPC_ZERO    = 3'd2;
    localparam logic [CMD_W-1:0] OPC_HOLD    = 3'd3;
    localparam logic [CMD_W-1:0] OPC_ABORT   = 3'd4;
    localparam logic [CMD_W-1:0] OPC_HELP    = 3'd5;
    localparam logic [CMD_W-1:0] OPC_UNKNOWN = 3'd6;

    // Error causes
    localparam logic [ERR_W-1:0] ERR_NONE       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN    = 3'd1;
    localparam logic [ERR_W-1:0] ERR_UNEXPECTED = 3'd2;
    localparam logic [ERR_W-1:0] ERR_AXIS       = 3'd3;
    localparam logic [ERR_W-1:0] ERR_STEPS      = 3'd4;
    localparam logic [ERR_W-1:0] ERR_RATE       = 3'd5;
    localparam logic [ERR_W-1:0] ERR_RATE_RANGE = 3'd6;
    localparam logic [ERR_W-1:0] ERR_NOT01      = 3'd7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LOWEST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_HIGHEST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEFAULT = 2'd3;

    localparam logic [CFG_MAG_W-1:0] RST_MAX_STEP     = 24'd16777215;
    localparam logic [RATE_W-1:0]    RST_RATE_LOWEST  = 16'd1;
    localparam logic [RATE_W-1:0]    RST_RATE_HIGHEST = 16'd65535;
    localparam logic [RATE_W-1:0]    RST_RATE_DEFAULT = 16'd1000;

    // Characters
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UH    = 8'h48;
    localparam logic [CH_W-1:0] CH_UM    = 8'h4D;
    localparam logic [CH_W-1:0] CH_US    = 8'h53;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_UY    = 8'h59;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [CFG_MAG_W-1:0] max_step_magnitude;
        logic [RATE_W-1:0]    rate_lowest;
        logic [RATE_W-1:0]    rate_highest;
        logic [RATE_W-1:0]    rate_default;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            eol;
    } item_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [ERR_W-1:0]         error_code;
        logic                     axis;
        logic                     both_axes;
        logic signed [STEP_W-1:0] step_count;
        logic [RATE_W-1:0]        step_rate;
        logic                     hold_enable;
    } result_t;

endpackage

// ===== src/mcld_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder configuration registers
// Holds the step limit and the rate range and default, written by index.
// ----------------------------------------------------------------------------
module mcld_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [mcld_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcld_pkg::CFG_MAG_W-1:0] cfg_data,
    output mcld_pkg::cfg_t                 cfg
);
    import mcld_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_STEP:     cfg_next.max_step_magnitude = cfg_data;
                CFG_RATE_LOWEST:  cfg_next.rate_lowest  = cfg_data[RATE_W-1:0];
                CFG_RATE_HIGHEST: cfg_next.rate_highest = cfg_data[RATE_W-1:0];
                CFG_RATE_DEFAULT: cfg_next.rate_default = cfg_data[RATE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_step_magnitude <= RST_MAX_STEP;
            cfg_reg.rate_lowest        <= RST_RATE_LOWEST;
            cfg_reg.rate_highest       <= RST_RATE_HIGHEST;
            cfg_reg.rate_default       <= RST_RATE_DEFAULT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/mcld_parser.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder parser
// Line parse state, updated once per character, and the end-of-line decode.
// ----------------------------------------------------------------------------
module mcld_parser #(
    parameter int MAGNITUDE_BITS = mcld_pkg::MAGNITUDE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  mcld_pkg::item_t   item,
    input  mcld_pkg::cfg_t    cfg,
    output mcld_pkg::result_t result
);
    import mcld_pkg::*;

    localparam int PROD_W = MAGNITUDE_BITS + 4;
    localparam int CMP_W  = ((MAGNITUDE_BITS > CFG_MAG_W) ? MAGNITUDE_BITS : CFG_MAG_W) + 4;
    localparam logic [MAGNITUDE_BITS-1:0] MAG_CAP = '1;

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_LEAD     = 4'd0;
    localparam logic [PH_W-1:0] PH_CMDCHK   = 4'd1;
    localparam logic [PH_W-1:0] PH_AXWAIT   = 4'd2;
    localparam logic [PH_W-1:0] PH_AXCHK    = 4'd3;
    localparam logic [PH_W-1:0] PH_NUMWAIT  = 4'd4;
    localparam logic [PH_W-1:0] PH_SIGN     = 4'd5;
    localparam logic [PH_W-1:0] PH_DIGITS   = 4'd6;
    localparam logic [PH_W-1:0] PH_RATEWAIT = 4'd7;
    localparam logic [PH_W-1:0] PH_TRAIL    = 4'd8;
    localparam logic [PH_W-1:0] PH_DONE     = 4'd9;

    typedef struct packed {
        logic [PH_W-1:0]           phase;
        logic [CMD_W-1:0]          cmd;
        logic                      axis_seen;
        logic                      axis_given;
        logic                      sign_negative;
        logic                      rate_given;
        logic [MAGNITUDE_BITS-1:0] magnitude;
        logic [STEP_W-1:0]         steps_held;
        logic [RATE_W-1:0]         rate_held;
        logic [ERR_W-1:0]          error_held;
    } parse_state_t;

    localparam parse_state_t LINE_CLEAR = '0;

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t final_state;

    function automatic logic is_blank(logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(logic [CH_W-1:0] c);
        return c inside {[CH_0:CH_9]};
    endfunction

    function automatic logic [ERR_W-1:0] slot_error(parse_state_t s);
        if (s.cmd == OPC_HOLD)
            return ERR_NOT01;
        return s.rate_given ? ERR_RATE : ERR_STEPS;
    endfunction

    function automatic parse_state_t fail(parse_state_t s, logic [ERR_W-1:0] code);
        parse_state_t t;
        t = s;
        t.error_held = code;
        t.phase = PH_DONE;
        return t;
    endfunction

    function automatic logic rate_bad(logic neg, logic [CMP_W-1:0] val, cfg_t c);
        return (neg && (val != '0)) || (val < CMP_W'(c.rate_lowest))
            || (val > CMP_W'(c.rate_highest));
    endfunction

    // Multiply by ten as two shifts and an add, then check against the clipped limit.
    function automatic parse_state_t add_digit(parse_state_t s, logic [CH_W-1:0] c,
                                               cfg_t k);
        parse_state_t       t;
        logic [PROD_W-1:0]  prod;
        logic [CMP_W-1:0]   limit;
        t = s;
        prod = (PROD_W'(s.magnitude) << 3) + (PROD_W'(s.magnitude) << 1)
             + PROD_W'(c[3:0]);
        limit = (CMP_W'(k.max_step_magnitude) > CMP_W'(MAG_CAP)) ?
                CMP_W'(MAG_CAP) : CMP_W'(k.max_step_magnitude);
        t.magnitude = prod[MAGNITUDE_BITS-1:0];
        if (CMP_W'(prod) > limit)
            t = fail(t, slot_error(t));
        else
            t.phase = PH_DIGITS;
        return t;
    endfunction

    function automatic parse_state_t number_start(parse_state_t s, logic [CH_W-1:0] c,
                                                  cfg_t k);
        parse_state_t t;
        t = s;
        t.magnitude = '0;
        t.sign_negative = 1'b0;
        if (c == CH_MINUS)
        begin
            t.sign_negative = 1'b1;
            t.phase = PH_SIGN;
        end
        else if (c == CH_PLUS)
            t.phase = PH_SIGN;
        else if (is_digit(c))
            t = add_digit(t, c, k);
        else
            t = fail(t, slot_error(t));
        return t;
    endfunction

    function automatic parse_state_t number_done(parse_state_t s);
        parse_state_t      t;
        logic [STEP_W-1:0] mag_ext;
        t = s;
        mag_ext = STEP_W'(s.magnitude);
        if ((s.cmd == OPC_MOVE) && !s.rate_given)
        begin
            t.steps_held = s.sign_negative ? (STEP_W'(0) - mag_ext) : mag_ext;
            t.phase = PH_RATEWAIT;
        end
        else
        begin
            if (s.cmd == OPC_MOVE)
                t.rate_held = RATE_W'(s.magnitude);
            t.phase = PH_TRAIL;
        end
        return t;
    endfunction

    function automatic parse_state_t enter_args(parse_state_t s);
        parse_state_t t;
        t = s;
        case (s.cmd)
            OPC_MOVE, OPC_ZERO, OPC_HOLD: t.phase = PH_AXWAIT;
            OPC_STATUS:                   t.phase = PH_TRAIL;
            OPC_ABORT:                    t.phase = PH_DONE;
            default:                      t = fail(s, ERR_UNKNOWN);
        endcase
        return t;
    endfunction

    // Close the line: complete a pending command letter or number, then judge
    // what is still missing.
    function automatic parse_state_t finish(parse_state_t s, cfg_t k);
        parse_state_t t;
        t = s;
        if (t.phase == PH_CMDCHK)
            t = enter_args(t);
        if (t.phase == PH_DIGITS)
            t = number_done(t);
        case (t.phase)
            PH_LEAD:
                t = fail(t, ERR_UNKNOWN);
            PH_AXWAIT:
                if (t.cmd == OPC_ZERO)
                begin
                    t.axis_given = 1'b0;
                    t.phase = PH_DONE;
                end
                else
                    t = fail(t, ERR_AXIS);
            PH_AXCHK:
                if (t.cmd == OPC_ZERO)
                    t.phase = PH_DONE;
                else
                    t = fail(t, (t.cmd == OPC_MOVE) ? ERR_STEPS : ERR_NOT01);
            PH_NUMWAIT, PH_SIGN:
                t = fail(t, slot_error(t));
            PH_RATEWAIT:
            begin
                t.rate_held = k.rate_default;
                t.sign_negative = 1'b0;
                if (rate_bad(1'b0, CMP_W'(k.rate_default), k))
                    t = fail(t, ERR_RATE_RANGE);
                else
                    t.phase = PH_DONE;
            end
            PH_TRAIL:
                if (t.cmd == OPC_MOVE)
                begin
                    if (rate_bad(t.sign_negative, CMP_W'(t.magnitude), k))
                        t = fail(t, ERR_RATE_RANGE);
                    else
                        t.phase = PH_DONE;
                end
                else if (t.cmd == OPC_HOLD)
                begin
                    if ((t.magnitude == '0)
                        || ((t.magnitude == MAGNITUDE_BITS'(1)) && !t.sign_negative))
                        t.phase = PH_DONE;
                    else
                        t = fail(t, ERR_NOT01);
                end
                else
                    t.phase = PH_DONE;
            default:
                t.phase = PH_DONE;
        endcase
        return t;
    endfunction

    function automatic logic [CMD_W-1:0] map_command(logic [CH_W-1:0] u);
        case (u)
            CH_UM:   return OPC_MOVE;
            CH_US:   return OPC_STATUS;
            CH_UZ:   return OPC_ZERO;
            CH_UH:   return OPC_HOLD;
            CH_UA:   return OPC_ABORT;
            default: return OPC_UNKNOWN;
        endcase
    endfunction

    function automatic parse_state_t take_char(parse_state_t s, logic [CH_W-1:0] c,
                                               cfg_t k);
        parse_state_t    t;
        logic [CH_W-1:0] u;
        t = s;
        u = (c inside {[CH_LA:CH_LZ]}) ? (c - CASE_OFS) : c;
        if (s.phase == PH_DONE)
            return s;
        // A NUL ends the line text; anything after it is ignored.
        if (c == CH_NUL)
            return finish(s, k);
        case (s.phase)
            PH_LEAD:
                if (!is_blank(c))
                begin
                    if (c == CH_QUERY)
                    begin
                        t.cmd = OPC_HELP;
                        t.phase = PH_DONE;
                    end
                    else
                    begin
                        t.cmd = map_command(u);
                        t.phase = PH_CMDCHK;
                    end
                end
            PH_CMDCHK:
                t = is_blank(c) ? enter_args(s) : fail(s, ERR_UNKNOWN);
            PH_AXWAIT:
                if (!is_blank(c))
                begin
                    if ((u == CH_UX) || (u == CH_UY))
                    begin
                        t.axis_seen = (u == CH_UY);
                        t.axis_given = 1'b1;
                        t.phase = PH_AXCHK;
                    end
                    else
                        t = fail(s, ERR_AXIS);
                end
            PH_AXCHK:
                if (!is_blank(c))
                    t = fail(s, ERR_AXIS);
                else
                    t.phase = (s.cmd == OPC_ZERO) ? PH_TRAIL : PH_NUMWAIT;
            PH_NUMWAIT:
                if (!is_blank(c))
                    t = number_start(s, c, k);
            PH_SIGN:
                t = is_digit(c) ? add_digit(s, c, k) : fail(s, slot_error(s));
            PH_DIGITS:
                if (is_digit(c))
                    t = add_digit(s, c, k);
                else if (is_blank(c))
                    t = number_done(s);
                else
                    t = fail(s, slot_error(s));
            PH_RATEWAIT:
                if (!is_blank(c))
                begin
                    t.rate_given = 1'b1;
                    t = number_start(t, c, k);
                end
            PH_TRAIL:
                if (!is_blank(c))
                begin
                    case (s.cmd)
                        OPC_STATUS: t = fail(s, ERR_UNEXPECTED);
                        OPC_ZERO:   t = fail(s, ERR_AXIS);
                        OPC_MOVE:   t = fail(s, ERR_RATE);
                        default:    t = fail(s, ERR_NOT01);
                    endcase
                end
            default:
                t.phase = PH_DONE;
        endcase
        return t;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        if (step)
            state_next = item.eol ? LINE_CLEAR : take_char(state_reg, item.ch, cfg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LINE_CLEAR;
        else
            state_reg <= state_next;
    end

    // Decode of the line as it would close now; taken only with an end of line.
    always_comb
    begin
        final_state = finish(state_reg, cfg);
        result = '0;
        result.error_code = final_state.error_held;
        if (final_state.error_held != ERR_NONE)
        begin
            result.command = (final_state.error_held == ERR_UNKNOWN) ?
                             OPC_MOVE : final_state.cmd;
        end
        else
        begin
            result.command = final_state.cmd;
            case (final_state.cmd)
                OPC_MOVE:
                begin
                    result.axis = final_state.axis_seen;
                    result.step_count = final_state.steps_held;
                    result.step_rate = final_state.rate_held;
                end
                OPC_ZERO:
                begin
                    result.axis = final_state.axis_given && final_state.axis_seen;
                    result.both_axes = !final_state.axis_given;
                end
                OPC_HOLD:
                begin
                    result.axis = final_state.axis_seen;
                    result.hold_enable = final_state.magnitude[0];
                end
                default:
                    result.axis = 1'b0;
            endcase
        end
    end

endmodule

// ===== src/mcld_out_reg.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder result register
// Holds one decoded command until the downstream side takes it.
// ----------------------------------------------------------------------------
module mcld_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mcld_pkg::result_t result_in,
    input  logic              take,
    output logic              valid,
    output mcld_pkg::result_t result_out
);
    import mcld_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result_in;
    end

    assign valid      = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== src/motion_command_line_decoder_top.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder
// Decodes a command line, one character per transfer, into one command.
// ----------------------------------------------------------------------------
// Characters enter on the s_axis channel, one per transfer; the transfer with
// s_axis_tlast set ends the line and its character is ignored. Every line
// gives exactly one result transfer on m_axis: the command in m_axis_tuser
// and the error code, axis, step count, rate and hold value in m_axis_tdata.
// Registers are written through the cfg channel (index, data); cfg_ready is
// always high, and writes belong to idle periods.
// A character is registered on acceptance and folded into the parse state
// on the next cycle, so one character is taken every cycle. The result of
// an end-of-line transfer goes through the input register and the result
// register to m_axis. While a result waits, characters keep flowing in;
// the input side stalls only when a second end of line reaches the parse
// stage before the waiting result is taken.
// Reset clears the parse state and restores the register defaults.
// ----------------------------------------------------------------------------
module motion_command_line_decoder_top #(
    parameter int MAGNITUDE_BITS = mcld_pkg::MAGNITUDE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mcld_pkg::CH_W-1:0]        s_axis_tdata,  // [7:0] ch
    input  logic                             s_axis_tlast,  // eol
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] error_code, [3] axis, [4] both_axes, [29:5] step_count,
    // [45:30] step_rate, [46] hold_enable, [47] zero
    output logic [mcld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [mcld_pkg::CMD_W-1:0]       m_axis_tuser,  // [2:0] command
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mcld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcld_pkg::CFG_MAG_W-1:0]   cfg_data
);
    import mcld_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    out_free;
    logic    step;
    result_t parsed;
    result_t shown;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign step          = in_valid_reg && (!in_item_reg.eol || out_free);
    assign s_axis_tready = !in_valid_reg || step;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (step)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.ch  <= s_axis_tdata;
            in_item_reg.eol <= s_axis_tlast;
        end
    end

    mcld_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mcld_parser #(
        .MAGNITUDE_BITS (MAGNITUDE_BITS)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (parsed)
    );

    mcld_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step && in_item_reg.eol),
        .result_in  (parsed),
        .take       (m_axis_tready),
        .valid      (m_axis_tvalid),
        .result_out (shown)
    );

    assign m_axis_tuser = shown.command;
    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, shown.hold_enable, shown.step_rate,
                           shown.step_count, shown.both_axes, shown.axis,
                           shown.error_code};

endmodule

// ===== src/mcld_checker.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder port checker
// Checks the result channel: results hold while stalled, command and fields agree.
// ----------------------------------------------------------------------------
`include "motion_command_line_decoder_top_macros.svh"

module mcld_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mcld_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [mcld_pkg::CMD_W-1:0]       m_axis_tuser
);
    import mcld_pkg::*;

    `MCLD_ASSERT(a_result_held,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser),
        "result changed while stalled")

    // Any error clears every field but command and error code.
    `MCLD_ASSERT(a_error_clean,
        m_axis_tvalid && (m_axis_tdata[2:0] != ERR_NONE) |-> (m_axis_tdata[46:3] == '0),
        "fields set with an error")

    `MCLD_ASSERT(a_unknown_cmd,
        m_axis_tvalid && (m_axis_tdata[2:0] == ERR_UNKNOWN) |-> (m_axis_tuser == OPC_MOVE),
        "unknown command not reported as zero")

    `MCLD_ASSERT(a_both_axes,
        m_axis_tvalid && m_axis_tdata[4] |-> (m_axis_tuser == OPC_ZERO) && !m_axis_tdata[3],
        "both axes outside a plain zero")

    `MCLD_ASSERT_NEVER(a_rate_move,
        m_axis_tvalid && (m_axis_tdata[45:30] != '0) && (m_axis_tuser != OPC_MOVE),
        "rate given outside a move")

endmodule

bind motion_command_line_decoder_top mcld_checker u_mcld_checker (.*);

// ===== test/motion_command_line_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// Motion command line decoder testbench
// Feeds command lines one character per transfer and checks every decoded
// command against a predictor of the line parser. The run goes through
// several register settings and through phases with idle and stall gaps.
// ----------------------------------------------------------------------------
module motion_command_line_decoder_top_tb;

    import mcld_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 8;

    typedef enum logic [3:0] {
        AT_LEAD, AT_CMD_END, AT_AXIS_WAIT, AT_AXIS_END, AT_NUM_WAIT,
        AT_SIGN, AT_DIGITS, AT_RATE_WAIT, AT_TRAIL, AT_DONE
    } line_phase_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CH_W-1:0]        s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [CMD_W-1:0]       m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_MAG_W-1:0]   cfg_data = '0;

    // Characters waiting for the driver, and decoded commands still owed.
    item_t   pending_chars[$];
    result_t expected_commands[$];
    item_t   next_char;
    result_t got_command;
    result_t want_command;

    int unsigned queued_total = 0;
    int unsigned accepted_chars = 0;
    int unsigned results_seen = 0;
    int unsigned fault_count = 0;
    int unsigned cycles_run = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    logic        sink_blocked = 1'b0;
    logic        char_taken = 1'b0;

    string hold_words[10] = '{"0", "1", "-0", "+1", "-1", "+0", "2", "01", "10", "00"};

    // Predictor copy of the registers.
    logic [CFG_MAG_W-1:0] mag_limit = RST_MAX_STEP;
    logic [RATE_W-1:0]    rate_floor = RST_RATE_LOWEST;
    logic [RATE_W-1:0]    rate_ceiling = RST_RATE_HIGHEST;
    logic [RATE_W-1:0]    rate_fallback = RST_RATE_DEFAULT;

    // Predictor copy of the parse state of the current line.
    line_phase_e       line_phase = AT_LEAD;
    logic [CMD_W-1:0]  line_cmd = OPC_MOVE;
    logic              line_on_y = 1'b0;
    logic              line_axis_named = 1'b0;
    logic              line_negative = 1'b0;
    logic [31:0]       line_magnitude = '0;
    logic [STEP_W-1:0] line_steps = '0;
    logic [31:0]       line_rate = '0;
    logic              line_rate_named = 1'b0;
    logic [ERR_W-1:0]  line_error = ERR_NONE;

    motion_command_line_decoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Line parser prediction
    // ------------------------------------------------------------------------
    function automatic logic is_blank(logic [CH_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic is_digit(logic [CH_W-1:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic void start_new_line();
        line_phase = AT_LEAD;
        line_cmd = OPC_MOVE;
        line_error = ERR_NONE;
        line_on_y = 1'b0;
        line_axis_named = 1'b0;
        line_negative = 1'b0;
        line_rate_named = 1'b0;
        line_magnitude = '0;
        line_steps = '0;
        line_rate = '0;
    endfunction

    function automatic void reject_line(logic [ERR_W-1:0] code);
        line_error = code;
        line_phase = AT_DONE;
    endfunction

    // A bad number is blamed on the field it stands in.
    function automatic logic [ERR_W-1:0] number_error();
        if (line_cmd == OPC_HOLD)
            return ERR_NOT01;
        return line_rate_named ? ERR_RATE : ERR_STEPS;
    endfunction

    function automatic void take_digit(logic [CH_W-1:0] c);
        line_magnitude = line_magnitude * 32'd10 + 32'(c - CH_0);
        if (line_magnitude > 32'(mag_limit))
            reject_line(number_error());
        else
            line_phase = AT_DIGITS;
    endfunction

    function automatic void start_number(logic [CH_W-1:0] c);
        line_magnitude = '0;
        line_negative = 1'b0;
        if (c == CH_MINUS)
        begin
            line_negative = 1'b1;
            line_phase = AT_SIGN;
        end
        else if (c == CH_PLUS)
            line_phase = AT_SIGN;
        else if (is_digit(c))
            take_digit(c);
        else
            reject_line(number_error());
    endfunction

    function automatic void end_number();
        if (line_cmd == OPC_MOVE && !line_rate_named)
        begin
            line_steps = line_negative ? STEP_W'(-line_magnitude) : STEP_W'(line_magnitude);
            line_phase = AT_RATE_WAIT;
        end
        else
        begin
            if (line_cmd == OPC_MOVE)
                line_rate = line_magnitude;
            line_phase = AT_TRAIL;
        end
    endfunction

    function automatic void open_arguments();
        case (line_cmd)
            OPC_MOVE, OPC_ZERO, OPC_HOLD: line_phase = AT_AXIS_WAIT;
            OPC_STATUS:                   line_phase = AT_TRAIL;
            OPC_ABORT:                    line_phase = AT_DONE;
            default:                      reject_line(ERR_UNKNOWN);
        endcase
    endfunction

    // Any nonzero negative rate is out of range, and so is everything when
    // the lowest rate lies above the highest.
    function automatic void judge_rate();
        if ((line_negative && line_rate != 0) || line_rate < 32'(rate_floor)
            || line_rate > 32'(rate_ceiling))
            reject_line(ERR_RATE_RANGE);
        else
            line_phase = AT_DONE;
    endfunction

    function automatic void finish_text();
        if (line_phase == AT_CMD_END)
            open_arguments();
        if (line_phase == AT_DIGITS)
            end_number();
        case (line_phase)
            AT_LEAD:
                reject_line(ERR_UNKNOWN);
            AT_AXIS_WAIT:
                if (line_cmd == OPC_ZERO)
                begin
                    line_axis_named = 1'b0;
                    line_phase = AT_DONE;
                end
                else
                    reject_line(ERR_AXIS);
            AT_AXIS_END:
                if (line_cmd == OPC_ZERO)
                    line_phase = AT_DONE;
                else
                    reject_line(line_cmd == OPC_MOVE ? ERR_STEPS : ERR_NOT01);
            AT_NUM_WAIT, AT_SIGN:
                reject_line(number_error());
            AT_RATE_WAIT:
            begin
                line_rate = 32'(rate_fallback);
                line_negative = 1'b0;
                judge_rate();
            end
            AT_TRAIL:
                if (line_cmd == OPC_MOVE)
                    judge_rate();
                else if (line_cmd == OPC_HOLD)
                begin
                    if (line_magnitude == 0 || (line_magnitude == 1 && !line_negative))
                        line_phase = AT_DONE;
                    else
                        reject_line(ERR_NOT01);
                end
                else
                    line_phase = AT_DONE;
            default:
                line_phase = AT_DONE;
        endcase
    endfunction

    function automatic void feed_char(logic [CH_W-1:0] c);
        logic [CH_W-1:0] up;
        up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
        if (line_phase == AT_DONE)
            return;
        // A NUL ends the text of the line; the rest up to the end is dropped.
        if (c == CH_NUL)
        begin
            finish_text();
            return;
        end
        case (line_phase)
            AT_LEAD:
                if (!is_blank(c))
                begin
                    if (c == CH_QUERY)
                    begin
                        line_cmd = OPC_HELP;
                        line_phase = AT_DONE;
                    end
                    else
                    begin
                        case (up)
                            CH_UM:   line_cmd = OPC_MOVE;
                            CH_US:   line_cmd = OPC_STATUS;
                            CH_UZ:   line_cmd = OPC_ZERO;
                            CH_UH:   line_cmd = OPC_HOLD;
                            CH_UA:   line_cmd = OPC_ABORT;
                            default: line_cmd = OPC_UNKNOWN;
                        endcase
                        line_phase = AT_CMD_END;
                    end
                end
            AT_CMD_END:
                if (is_blank(c))
                    open_arguments();
                else
                    reject_line(ERR_UNKNOWN);
            AT_AXIS_WAIT:
                if (!is_blank(c))
                begin
                    if (up == CH_UX || up == CH_UY)
                    begin
                        line_on_y = up == CH_UY;
                        line_axis_named = 1'b1;
                        line_phase = AT_AXIS_END;
                    end
                    else
                        reject_line(ERR_AXIS);
                end
            AT_AXIS_END:
                if (!is_blank(c))
                    reject_line(ERR_AXIS);
                else if (line_cmd == OPC_ZERO)
                    line_phase = AT_TRAIL;
                else
                    line_phase = AT_NUM_WAIT;
            AT_NUM_WAIT:
                if (!is_blank(c))
                    start_number(c);
            AT_SIGN:
                if (is_digit(c))
                    take_digit(c);
                else
                    reject_line(number_error());
            AT_DIGITS:
                if (is_digit(c))
                    take_digit(c);
                else if (is_blank(c))
                    end_number();
                else
                    reject_line(number_error());
            AT_RATE_WAIT:
                if (!is_blank(c))
                begin
                    line_rate_named = 1'b1;
                    start_number(c);
                end
            AT_TRAIL:
                if (!is_blank(c))
                begin
                    case (line_cmd)
                        OPC_STATUS: reject_line(ERR_UNEXPECTED);
                        OPC_ZERO:   reject_line(ERR_AXIS);
                        OPC_MOVE:   reject_line(ERR_RATE);
                        default:    reject_line(ERR_NOT01);
                    endcase
                end
            default:
                line_phase = AT_DONE;
        endcase
    endfunction

    // Ends the current line and returns the command it decodes to. Fields a
    // command does not use stay zero, and so does everything after an error.
    function automatic result_t close_line();
        result_t r;
        finish_text();
        r = '0;
        r.error_code = line_error;
        if (line_error != ERR_NONE)
            r.command = (line_error == ERR_UNKNOWN) ? '0 : line_cmd;
        else
        begin
            r.command = line_cmd;
            case (line_cmd)
                OPC_MOVE:
                begin
                    r.axis = line_on_y;
                    r.step_count = line_steps;
                    r.step_rate = line_rate[RATE_W-1:0];
                end
                OPC_ZERO:
                begin
                    r.axis = line_axis_named && line_on_y;
                    r.both_axes = !line_axis_named;
                end
                OPC_HOLD:
                begin
                    r.axis = line_on_y;
                    r.hold_enable = line_magnitude[0];
                end
                default: ;
            endcase
        end
        start_new_line();
        return r;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_MAG_W-1:0] value);
        case (idx)
            CFG_MAX_STEP:     mag_limit = value;
            CFG_RATE_LOWEST:  rate_floor = value[RATE_W-1:0];
            CFG_RATE_HIGHEST: rate_ceiling = value[RATE_W-1:0];
            CFG_RATE_DEFAULT: rate_fallback = value[RATE_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic string describe(result_t r);
        return $sformatf("cmd=%0d err=%0d axis=%0d both=%0d steps=%0d rate=%0d hold=%0d",
                         r.command, r.error_code, r.axis, r.both_axes, r.step_count,
                         r.step_rate, r.hold_enable);
    endfunction

    task automatic log_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got_command.command = m_axis_tuser;
                got_command.error_code = m_axis_tdata[2:0];
                got_command.axis = m_axis_tdata[3];
                got_command.both_axes = m_axis_tdata[4];
                got_command.step_count = m_axis_tdata[29:5];
                got_command.step_rate = m_axis_tdata[45:30];
                got_command.hold_enable = m_axis_tdata[46];
                if (expected_commands.size() == 0)
                    log_fault($sformatf("result %0d with no line pending: %s",
                                        results_seen, describe(got_command)));
                else
                begin
                    want_command = expected_commands.pop_front();
                    if (got_command.command !== want_command.command
                        || got_command.error_code !== want_command.error_code
                        || got_command.axis !== want_command.axis
                        || got_command.both_axes !== want_command.both_axes
                        || got_command.step_count !== want_command.step_count
                        || got_command.step_rate !== want_command.step_rate
                        || got_command.hold_enable !== want_command.hold_enable)
                        log_fault($sformatf("result %0d: got %s, expected %s", results_seen,
                                            describe(got_command), describe(want_command)));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                accepted_chars++;
                if (s_axis_tlast)
                    expected_commands.push_back(close_line());
                else
                    feed_char(s_axis_tdata);
            end
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
        char_taken <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    always @(posedge clk)
    begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Character driver and result sink
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || char_taken))
        begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                next_char = pending_chars.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_char.ch;
                s_axis_tlast <= next_char.eol;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || sink_blocked)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= $urandom_range(99) >= snk_stall_pct;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_char(logic [CH_W-1:0] c);
        pending_chars.push_back('{ch: c, eol: 1'b0});
        queued_total++;
    endtask

    task automatic queue_text(string s);
        foreach (s[i])
            queue_char(s[i]);
    endtask

    task automatic queue_eol();
        pending_chars.push_back('{ch: CH_W'($urandom_range(255)), eol: 1'b1});
        queued_total++;
    endtask

    task automatic queue_line(string s);
        queue_text(s);
        queue_eol();
    endtask

    function automatic string gap(int unsigned least);
        string s;
        s = "";
        repeat ($urandom_range(least, least + 2))
        begin
            if ($urandom_range(3) == 0)
                s = {s, "\t"};
            else
                s = {s, " "};
        end
        return s;
    endfunction

    function automatic string letter_case(string s);
        if ($urandom_range(1))
            return s.tolower();
        return s;
    endfunction

    function automatic string pick_axis_letter();
        string s;
        if ($urandom_range(1))
            s = "Y";
        else
            s = "X";
        return letter_case(s);
    endfunction

    // Decimal text that lands on, just past, well inside or far beyond the given bounds.
    function automatic string number_text(int unsigned near_lo, int unsigned near_hi);
        int unsigned v;
        string s;
        case ($urandom_range(7))
            0:       v = $urandom_range(9);
            1:       v = near_lo;
            2:       v = near_hi;
            3:       v = near_hi + 1;
            4:       v = (near_lo == 0) ? 0 : near_lo - 1;
            5:       v = $urandom_range(near_hi);
            6:       v = $urandom_range(32'h01FF_FFFF);
            default: v = $urandom_range(99999);
        endcase
        s = $sformatf("%0d", v);
        if ($urandom_range(7) == 0)
            s = {"00", s};
        case ($urandom_range(9))
            0, 1:    s = {"-", s};
            2:       s = {"+", s};
            default: ;
        endcase
        return s;
    endfunction

    task automatic queue_random_line();
        string txt;
        logic [CH_W-1:0] raw[$];
        int unsigned pos;
        txt = "";
        case ($urandom_range(11))
            0, 1, 2, 3:
            begin
                txt = {gap(0), letter_case("M"), gap(1), pick_axis_letter(), gap(1),
                       number_text(0, mag_limit)};
                if ($urandom_range(2) != 0)
                    txt = {txt, gap(1), number_text(rate_floor, rate_ceiling)};
                txt = {txt, gap(0)};
            end
            4, 5:
            begin
                txt = {gap(0), letter_case("H"), gap(1), pick_axis_letter(), gap(1)};
                if ($urandom_range(3) == 0)
                    txt = {txt, number_text(0, mag_limit)};
                else
                    txt = {txt, hold_words[$urandom_range(9)]};
                txt = {txt, gap(0)};
            end
            6, 7:
            begin
                txt = {gap(0), letter_case("Z")};
                if ($urandom_range(2) != 0)
                    txt = {txt, gap(1), pick_axis_letter()};
                txt = {txt, gap(0)};
            end
            8, 9:
            begin
                case ($urandom_range(2))
                    0:       txt = {gap(0), letter_case("S")};
                    1:       txt = {gap(0), letter_case("A")};
                    default: txt = {gap(0), "?"};
                endcase
                if ($urandom_range(1))
                    txt = {txt, gap(1), pick_axis_letter(), number_text(0, 99)};
            end
            default:
                repeat ($urandom_range(10))
                    raw.push_back(CH_W'($urandom_range(255)));
        endcase
        foreach (txt[i])
            raw.push_back(txt[i]);
        // Break some lines: a stray byte, a cut, or an early NUL.
        if ($urandom_range(4) == 0 && raw.size() != 0)
        begin
            pos = $urandom_range(raw.size() - 1);
            case ($urandom_range(2))
                0: raw[pos] = CH_W'($urandom_range(255));
                1: while (raw.size() > pos) void'(raw.pop_back());
                default: raw.insert(pos, CH_NUL);
            endcase
        end
        foreach (raw[i])
            queue_char(raw[i]);
        queue_eol();
    endtask

    task automatic fill_to(int unsigned target);
        while (queued_total < target)
            queue_random_line();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_chars != queued_total || expected_commands.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_MAG_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_pace(int unsigned src_pct, int unsigned snk_pct);
        @(posedge clk);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    initial
    begin
        int unsigned lo_pick;
        int unsigned hi_pick;
        logic [7:0]  junk;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed lines under the reset settings.
        set_pace(0, 0);
        queue_line("");
        queue_line("   ");
        queue_line("?zz");
        queue_line("a junk");
        queue_line("s");
        queue_line("S 9");
        queue_line("z");
        queue_line("\tZ y ");
        queue_line("Zx");
        queue_line("z q");
        queue_line("h x -0");
        queue_line("H Y +1");
        queue_line("h x 2");
        queue_line("h y");
        queue_line("m x -16777215 65535");
        queue_line("M Y 16777216");
        queue_line("m y +7");
        queue_line("m x 5 -0");
        queue_line("m x 5 -3");
        queue_line("m x 5 70000");
        queue_line("m x 5 9z");
        queue_line("m x 12 7 8");
        queue_line("m\t");
        queue_line("m x");
        queue_line("m y -");
        queue_line("Q");
        queue_text("s");
        queue_char(CH_NUL);
        queue_line("junk");
        queue_char(8'hCD);
        queue_line("x");
        fill_to(330);
        wait_drained();

        write_register(CFG_MAX_STEP, 24'd999);
        write_register(CFG_RATE_LOWEST, 24'd100);
        write_register(CFG_RATE_HIGHEST, 24'd5000);
        write_register(CFG_RATE_DEFAULT, 24'd2500);
        set_pace(85, 0);
        fill_to(640);
        wait_drained();

        // Only a zero magnitude passes, and only rate 1.
        write_register(CFG_MAX_STEP, 24'd0);
        write_register(CFG_RATE_LOWEST, 24'd1);
        write_register(CFG_RATE_HIGHEST, 24'd1);
        write_register(CFG_RATE_DEFAULT, 24'd1);
        set_pace(0, 85);
        fill_to(900);
        wait_drained();

        write_register(CFG_MAX_STEP, 24'hFF_FFFF);
        write_register(CFG_RATE_LOWEST, 24'd65535);
        write_register(CFG_RATE_HIGHEST, 24'd65535);
        write_register(CFG_RATE_DEFAULT, 24'd65535);
        set_pace(37, 37);
        fill_to(1160);
        wait_drained();

        // Crossed rate limits, while the sink holds off long enough for the
        // decoder to back up into its input.
        write_register(CFG_MAX_STEP, CFG_MAG_W'($urandom_range(1, 50000)));
        write_register(CFG_RATE_LOWEST, 24'd500);
        write_register(CFG_RATE_HIGHEST, 24'd100);
        write_register(CFG_RATE_DEFAULT, 24'd300);
        set_pace(0, 0);
        fill_to(1400);
        @(posedge clk);
        sink_blocked = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        sink_blocked = 1'b0;
        wait_drained();

        // Random settings; upper data bits of the rate registers are noise.
        lo_pick = $urandom_range(1, 1000);
        hi_pick = $urandom_range(lo_pick, 65535);
        write_register(CFG_MAX_STEP, CFG_MAG_W'($urandom_range(24'hFF_FFFF)));
        junk = 8'($urandom_range(255));
        write_register(CFG_RATE_LOWEST, {junk, 16'(lo_pick)});
        junk = 8'($urandom_range(255));
        write_register(CFG_RATE_HIGHEST, {junk, 16'(hi_pick)});
        junk = 8'($urandom_range(255));
        write_register(CFG_RATE_DEFAULT, {junk, 16'($urandom_range(1, 65535))});
        set_pace(37, 37);
        fill_to(1660);
        wait_drained();

        if (fault_count == 0 && expected_commands.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
